// ----- rtl/core/smpq_pkg.sv -----
package smpq_pkg;

  localparam int unsigned CapacityDef = 16;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               hit;
    logic signed [31:0] data;
    logic signed [31:0] prio;
    logic [4:0]         occupancy;
  } result_t;

endpackage

// ----- rtl/core/smpq_mem.sv -----
module smpq_mem #(
  parameter int unsigned Depth = smpq_pkg::CapacityDef,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [Aw-1:0]   waddr_i,
  input  smpq_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [Aw-1:0]   raddr_i,
  output smpq_pkg::entry_t rdata_o
);

  smpq_pkg::entry_t mem_q [Depth];
  smpq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/smpq_ctrl.sv -----
module smpq_ctrl #(
  parameter int unsigned Capacity = smpq_pkg::CapacityDef,
  parameter int unsigned Aw       = $clog2(Capacity),
  parameter int unsigned Cw       = $clog2(Capacity + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic signed [31:0] item_data_i,
  input  logic signed [31:0] item_priority_i,
  output logic              mem_we_o,
  output logic [Aw-1:0]     mem_waddr_o,
  output smpq_pkg::entry_t  mem_wdata_o,
  output logic              mem_re_o,
  output logic [Aw-1:0]     mem_raddr_o,
  input  smpq_pkg::entry_t  mem_rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output smpq_pkg::result_t res_o
);

  localparam int unsigned Sw = Aw + 1;
  localparam logic [Aw-1:0] LastIdx = Aw'(Capacity - 1);
  localparam logic [Cw-1:0] Full = Cw'(Capacity);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_HEAD   = 4'b0010,
    S_WALK   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [Aw-1:0] head_q, head_d;
  logic [Cw-1:0] count_q, count_d;
  logic [Aw-1:0] k_q, k_d;
  logic [Cw-1:0] rem_q, rem_d;
  logic [1:0] cmd_q, cmd_d;
  smpq_pkg::entry_t item_q, item_d;
  logic [1:0] status_q, status_d;
  logic hit_q, hit_d;
  smpq_pkg::entry_t rentry_q, rentry_d;
  logic [Sw-1:0] tail_sum;
  logic [Aw-1:0] tail_idx;

  function automatic logic [Aw-1:0] idx_inc(input logic [Aw-1:0] a);
    return (a == LastIdx) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [Aw-1:0] idx_dec(input logic [Aw-1:0] a);
    return (a == '0) ? LastIdx : a - 1'b1;
  endfunction

  always_comb begin
    tail_sum = {1'b0, head_q} + Sw'(count_q) - 1'b1;
    if (tail_sum >= Sw'(Capacity)) begin
      tail_sum = tail_sum - Sw'(Capacity);
    end
    tail_idx = tail_sum[Aw-1:0];
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    k_d         = k_q;
    rem_d       = rem_q;
    cmd_d       = cmd_q;
    item_d      = item_q;
    status_d    = status_q;
    hit_d       = hit_q;
    rentry_d    = rentry_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_inc(k_q);
    mem_wdata_o = item_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = command_i;
          item_d.data = item_data_i;
          item_d.prio = item_priority_i;
          status_d    = smpq_pkg::ST_DONE;
          hit_d       = 1'b0;
          rentry_d    = '0;
          state_d     = S_FINISH;
          unique case (command_i)
            smpq_pkg::CMD_INSERT: begin
              if (count_q == Full) begin
                status_d = smpq_pkg::ST_FULL;
              end else if (count_q == '0) begin
                mem_we_o         = 1'b1;
                mem_waddr_o      = head_q;
                mem_wdata_o.data = item_data_i;
                mem_wdata_o.prio = item_priority_i;
                count_d          = count_q + 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = tail_idx;
                k_d         = tail_idx;
                rem_d       = count_q;
                state_d     = S_WALK;
              end
            end
            smpq_pkg::CMD_EXTRACT, smpq_pkg::CMD_PEEK: begin
              if (count_q == '0) begin
                status_d = smpq_pkg::ST_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                state_d     = S_HEAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_HEAD: begin
        hit_d    = 1'b1;
        rentry_d = mem_rdata_i;
        if (cmd_q == smpq_pkg::CMD_EXTRACT) begin
          head_d  = idx_inc(head_q);
          count_d = count_q - 1'b1;
        end
        state_d = S_FINISH;
      end
      S_WALK: begin
        mem_we_o = 1'b1;
        if (rem_q == '0 || mem_rdata_i.prio >= item_q.prio) begin
          count_d = count_q + 1'b1;
          state_d = S_FINISH;
        end else begin
          mem_wdata_o = mem_rdata_i;
          rem_d       = rem_q - 1'b1;
          k_d         = idx_dec(k_q);
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_dec(k_q);
        end
      end
      S_FINISH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    rem_q    <= rem_d;
    cmd_q    <= cmd_d;
    item_q   <= item_d;
    status_q <= status_d;
    hit_q    <= hit_d;
    rentry_q <= rentry_d;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign res_valid_o     = (state_q == S_FINISH);
  assign res_o.status    = status_q;
  assign res_o.hit       = hit_q;
  assign res_o.data      = rentry_q.data;
  assign res_o.prio      = rentry_q.prio;
  assign res_o.occupancy = 5'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above capacity");

  a_walk_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> rem_q <= count_q && count_q != Full)
    else $error("insert walk longer than stored list");

  a_write_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> state_q == S_WALK || (state_q == S_IDLE && count_q == '0))
    else $error("memory write outside insert");

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.hit |-> res_o.status == smpq_pkg::ST_DONE)
    else $error("head entry reported with error status");

  a_extract_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HEAD && cmd_q == smpq_pkg::CMD_EXTRACT |=> count_q == $past(count_q) - 1'b1)
    else $error("extract did not drop one entry");

endmodule

// ----- rtl/core/sorted_max_priority_queue.sv -----
// Bounded max-priority queue kept in descending priority order in one
// synchronous RAM used as a ring starting at a head pointer; equal priorities
// leave first-in first-out. Each item on the input channel is one command and
// gives one item on the output channel. Extract and peek read the head slot
// from the RAM, then pass through S_HEAD and S_FINISH to the output register.
// An insert walks back from the tail, reading one slot and writing it one
// place down per cycle. It moves each stored entry of lower priority, then
// writes the new item, and its result passes through S_FINISH to the output
// register. Full, empty and unused commands and an insert into an empty queue
// go from S_IDLE straight to S_FINISH. The next command is accepted once the
// current result has entered the output register, which holds it while the
// output stalls. No clearing pass follows reset.
module sorted_max_priority_queue #(
  parameter int unsigned CAPACITY = smpq_pkg::CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic signed [31:0] item_data_i,
  input  logic signed [31:0] item_priority_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic              result_valid_o,
  output logic signed [31:0] result_data_o,
  output logic signed [31:0] result_priority_o,
  output logic [4:0]        occupancy_o
);

  localparam int unsigned Aw = $clog2(CAPACITY);
  localparam int unsigned Cw = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [Aw-1:0]     mem_waddr;
  smpq_pkg::entry_t  mem_wdata;
  logic              mem_re;
  logic [Aw-1:0]     mem_raddr;
  smpq_pkg::entry_t  mem_rdata;
  logic              res_valid;
  logic              res_ready;
  smpq_pkg::result_t res;
  logic              out_valid_q;
  smpq_pkg::result_t out_q;

  smpq_mem #(
    .Depth(CAPACITY),
    .Aw   (Aw)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  smpq_ctrl #(
    .Capacity(CAPACITY),
    .Aw      (Aw),
    .Cw      (Cw)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .item_data_i    (item_data_i),
    .item_priority_i(item_priority_i),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  assign res_ready = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign result_valid_o    = out_q.hit;
  assign result_data_o     = out_q.data;
  assign result_priority_o = out_q.prio;
  assign occupancy_o       = out_q.occupancy;

endmodule

// ----- sim/smpq_result_monitor.sv -----
`timescale 1ns / 100ps

module smpq_result_monitor #(
  parameter int unsigned CAPACITY = smpq_pkg::CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] item_data_i,
  input  logic signed [31:0] item_priority_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic               result_valid_i,
  input  logic signed [31:0] result_data_i,
  input  logic signed [31:0] result_priority_i,
  input  logic [4:0]         occupancy_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o
);

  smpq_pkg::entry_t  sorted_slots[CAPACITY];
  int unsigned       stored_count;
  smpq_pkg::result_t queued_results[$];

  function automatic smpq_pkg::result_t apply_command(input logic [1:0] cmd,
                                                      input logic signed [31:0] data,
                                                      input logic signed [31:0] prio);
    smpq_pkg::result_t res;
    int unsigned       pos;
    res = '0;
    case (cmd)
      smpq_pkg::CMD_INSERT: begin
        if (stored_count >= CAPACITY) begin
          res.status = smpq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < stored_count && $signed(sorted_slots[pos].prio) >= $signed(prio))
            pos++;
          for (int unsigned i = stored_count; i > pos; i--)
            sorted_slots[i] = sorted_slots[i - 1];
          sorted_slots[pos].data = data;
          sorted_slots[pos].prio = prio;
          stored_count++;
        end
      end
      smpq_pkg::CMD_EXTRACT, smpq_pkg::CMD_PEEK: begin
        if (stored_count == 0) begin
          res.status = smpq_pkg::ST_EMPTY;
        end else begin
          res.hit  = 1'b1;
          res.data = sorted_slots[0].data;
          res.prio = sorted_slots[0].prio;
          if (cmd == smpq_pkg::CMD_EXTRACT) begin
            for (int unsigned i = 0; i + 1 < stored_count; i++)
              sorted_slots[i] = sorted_slots[i + 1];
            stored_count--;
          end
        end
      end
      default: ;
    endcase
    res.occupancy = stored_count[4:0];
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin
    smpq_pkg::result_t exp_res;
    if (!rst_ni) begin
      stored_count = 0;
      queued_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (queued_results.size() == 0) begin
          $display("%0t: unexpected item, status %0h valid %0b data %0h prio %0h occ %0d",
                   $time, status_i, result_valid_i, result_data_i, result_priority_i,
                   occupancy_i);
          mismatches_o++;
        end else begin
          exp_res = queued_results.pop_front();
          compare_field("status", 32'(exp_res.status), 32'(status_i));
          compare_field("result_valid", 32'(exp_res.hit), 32'(result_valid_i));
          compare_field("result_data", exp_res.data, result_data_i);
          compare_field("result_priority", exp_res.prio, result_priority_i);
          compare_field("occupancy", 32'(exp_res.occupancy), 32'(occupancy_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        queued_results.push_back(apply_command(command_i, item_data_i, item_priority_i));
    end
    pending_o = queued_results.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned StuckLimit = 3000;
  localparam int unsigned RandomItems = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic signed [31:0] item_data;
  logic signed [31:0] item_priority;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic               result_valid;
  logic signed [31:0] result_data;
  logic signed [31:0] result_priority;
  logic [4:0]         occupancy;
  int unsigned        mismatches;
  int unsigned        pending;
  int unsigned        stuck_cycles;
  bit                 long_hold_req;
  bit                 sender_quiet;

  sorted_max_priority_queue u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .item_data_i      (item_data),
    .item_priority_i  (item_priority),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .result_valid_o   (result_valid),
    .result_data_o    (result_data),
    .result_priority_o(result_priority),
    .occupancy_o      (occupancy)
  );

  smpq_result_monitor u_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .item_data_i      (item_data),
    .item_priority_i  (item_priority),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .result_valid_i   (result_valid),
    .result_data_i    (result_data),
    .result_priority_i(result_priority),
    .occupancy_i      (occupancy),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    out_stall <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        len = 400;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            out_stall <= 1'b0;
            len = $urandom_range(20, 80);
          end
          3: begin
            out_stall <= 1'b1;
            len = $urandom_range(10, 50);
          end
          default: begin
            out_stall <= 1'($urandom_range(0, 1));
            len = $urandom_range(1, 3);
          end
        endcase
      end
      repeat (len) @(posedge clk_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return int'($urandom_range(0, 6)) - 3;
      3: return int'($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] data,
                           input logic signed [31:0] prio, input int unsigned gap);
    in_valid      <= 1'b1;
    command       <= cmd;
    item_data     <= data;
    item_priority <= prio;
    do @(posedge clk_i); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned        insert_pct;
    int unsigned        epoch_left;
    logic [1:0]         cmd;
    int unsigned        r;
    long_hold_req = 1'b0;
    sender_quiet  = 1'b0;
    stuck_cycles  = 0;
    rst_ni        <= 1'b0;
    in_valid      <= 1'b0;
    command       <= smpq_pkg::CMD_INSERT;
    item_data     <= '0;
    item_priority <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(smpq_pkg::CMD_PEEK, 32'sh0, 32'sh0, pick_gap());
    send_item(smpq_pkg::CMD_EXTRACT, 32'sh0, 32'sh0, pick_gap());
    send_item(CMD_UNUSED, -32'sd1, -32'sd1, pick_gap());
    send_item(smpq_pkg::CMD_INSERT, 32'sh80000000, 32'sh7fffffff, pick_gap());
    send_item(smpq_pkg::CMD_INSERT, 32'sh7fffffff, 32'sh80000000, pick_gap());
    send_item(smpq_pkg::CMD_INSERT, 32'sd0, 32'sd0, pick_gap());
    send_item(smpq_pkg::CMD_INSERT, 32'sd1, 32'sd0, pick_gap());
    send_item(smpq_pkg::CMD_INSERT, 32'sd2, 32'sd0, pick_gap());
    send_item(smpq_pkg::CMD_INSERT, -32'sd1, -32'sd1, pick_gap());
    send_item(smpq_pkg::CMD_INSERT, 32'sd5, 32'sh7fffffff, pick_gap());
    send_item(smpq_pkg::CMD_PEEK, 32'sh0, 32'sh0, pick_gap());
    repeat (7) send_item(smpq_pkg::CMD_EXTRACT, 32'sh0, 32'sh0, pick_gap());
    send_item(smpq_pkg::CMD_EXTRACT, 32'sh0, 32'sh0, pick_gap());
    send_item(CMD_UNUSED, 32'sh0, 32'sh0, 1);
    wait_drained();

    epoch_left = 0;
    insert_pct = 50;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (epoch_left == 0) begin
        epoch_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0: insert_pct = 80;
          1: insert_pct = 50;
          default: insert_pct = 25;
        endcase
        sender_quiet = ($urandom_range(0, 9) < 3);
      end
      epoch_left--;
      if (n == 500) long_hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r == 0) cmd = CMD_UNUSED;
      else if (r <= insert_pct) cmd = smpq_pkg::CMD_INSERT;
      else if ($urandom_range(0, 3) == 0) cmd = smpq_pkg::CMD_PEEK;
      else cmd = smpq_pkg::CMD_EXTRACT;
      if (n == 1000) begin
        send_item(cmd, pick_value(), pick_value(), 1);
        wait_drained();
      end else begin
        send_item(cmd, pick_value(), pick_value(), pick_gap());
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
